// ----- rtl/dtd_pkg.sv -----
// dtd_pkg: shared types and constants of the dictionary token decompressor
// no dependencies

package dtd_pkg;

  // input word kinds carried in s_axis_tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  // control tokens of the compressed stream
  localparam logic [7:0] TOK_END    = 8'd0;
  localparam logic [7:0] TOK_RUN    = 8'd1;
  localparam logic [7:0] TOK_SINGLE = 8'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TWO_START    = 2'd0;
  localparam logic [1:0] CFG_THREE_START  = 2'd1;
  localparam logic [1:0] CFG_THREE_OFFSET = 2'd2;

  localparam logic [7:0] TWO_START_RST    = 8'd128;
  localparam logic [7:0] THREE_START_RST  = 8'd192;
  localparam logic [9:0] THREE_OFFSET_RST = 10'd256;

  // raw dictionary offset before folding into the ram range
  localparam int OFF_W   = 11;
  localparam int OFF_MAX = 1788;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COUNT,
    PH_LIT,
    PH_CHAR,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    SQ_ACCEPT,
    SQ_ADDR,
    SQ_DATA
  } seq_e;

  typedef struct packed {
    logic [7:0] two_char_start;
    logic [7:0] three_char_start;
    logic [9:0] three_char_offset;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       truncated;
  } out_item_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ram_cmd_t;

endpackage

// ----- rtl/dictionary_token_decompressor.sv -----
// Dictionary token decompressor: turns a compressed byte stream into characters,
// using a loaded dictionary ram. A load word, or a decode word that needs no
// dictionary lookup, is completed in its accept step. A dictionary code for an entry
// of n characters (n = 1 to 3) is accepted, then the SQ_ADDR state folds the entry
// offset into the ram range and issues the first read, then each character is one read
// of the single-port-read dictionary ram. Stalls on the output side hold the sequence.
// The dictionary has no reset and no clearing pass; entries must be loaded before use.
// Depends on dtd_pkg, dtd_token_ctrl and dtd_dict_ram.

module dictionary_token_decompressor #(
  parameter int DICT_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [9:0] dict_address, [17:10] dict_value, [25:18] code_byte, [33:26] capacity
  input  logic [39:0] s_axis_tdata,
  // [0] operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_char
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] truncated
  output logic        m_axis_tuser
);

  import dtd_pkg::*;

  localparam int AW = $clog2(DICT_DEPTH);

  cfg_t      cfg_q, cfg_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;
  logic      out_free;
  logic      emit;
  out_item_t emit_item;
  ram_cmd_t  ram_cmd;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TWO_START:    cfg_d.two_char_start    = cfg_data_i[7:0];
        CFG_THREE_START:  cfg_d.three_char_start  = cfg_data_i[7:0];
        CFG_THREE_OFFSET: cfg_d.three_char_offset = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.two_char_start    <= TWO_START_RST;
      cfg_q.three_char_start  <= THREE_START_RST;
      cfg_q.three_char_offset <= THREE_OFFSET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dtd_token_ctrl #(
    .DICT_DEPTH(DICT_DEPTH),
    .AW        (AW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .in_op_i          (s_axis_tuser),
    .in_dict_address_i(s_axis_tdata[9:0]),
    .in_dict_value_i  (s_axis_tdata[17:10]),
    .in_code_i        (s_axis_tdata[25:18]),
    .in_capacity_i    (s_axis_tdata[33:26]),
    .out_free_i       (out_free),
    .emit_o           (emit),
    .emit_item_o      (emit_item),
    .ram_cmd_o        (ram_cmd),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data)
  );

  dtd_dict_ram #(
    .DICT_DEPTH(DICT_DEPTH),
    .AW        (AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_cmd.wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (ram_cmd.rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // output word register
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_free) begin
      out_valid_d = emit;
      out_item_d  = emit_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_item_q.out_char;
  assign m_axis_tlast  = out_item_q.last;
  assign m_axis_tuser  = out_item_q.truncated;

  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> out_free)
    else $error("word emitted while output register is occupied");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_cmd.wr_en && ram_cmd.rd_en))
    else $error("dictionary load overlaps a dictionary fetch");

  a_load_no_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_LOAD) |-> !emit)
    else $error("dictionary load produced an output word");

  a_term_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.last || out_item_q.truncated)) |->
      (out_item_q.last && out_item_q.out_char == 8'd0))
    else $error("malformed terminator word");

endmodule

// ----- rtl/dtd_dict_ram.sv -----
// dtd_dict_ram: dictionary byte store, one write and one read port
// read data registered; no dependencies

module dtd_dict_ram #(
  parameter int DICT_DEPTH = 1024,
  parameter int AW         = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DICT_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/dtd_token_ctrl.sv -----
// dtd_token_ctrl: token parser, string capacity tracking and dictionary fetch sequencer
// depends on dtd_pkg; drives dtd_dict_ram

module dtd_token_ctrl #(
  parameter int DICT_DEPTH = 1024,
  parameter int AW         = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dtd_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_op_i,
  input  logic [9:0]         in_dict_address_i,
  input  logic [7:0]         in_dict_value_i,
  input  logic [7:0]         in_code_i,
  input  logic [7:0]         in_capacity_i,
  input  logic               out_free_i,
  output logic               emit_o,
  output dtd_pkg::out_item_t emit_item_o,
  output dtd_pkg::ram_cmd_t  ram_cmd_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [7:0]         wr_data_o,
  output logic [AW-1:0]      rd_addr_o,
  input  logic [7:0]         rd_data_i
);

  import dtd_pkg::*;

  localparam int VW        = (AW + 1 > OFF_W) ? AW + 1 : OFF_W;
  localparam int RED_STEPS = OFF_MAX / DICT_DEPTH;
  localparam logic [VW-1:0] DEPTH_V = VW'(DICT_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DICT_DEPTH - 1);

  seq_e           seq_q, seq_d;
  phase_e         phase_q, phase_d;
  logic [7:0]     lit_q, lit_d;
  logic [7:0]     space_q, space_d;
  logic           active_q, active_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [AW-1:0]  ptr_q, ptr_d;

  phase_e           cur_phase;
  logic [7:0]       cur_space;
  logic [7:0]       cur_lit;
  logic [7:0]       diff3, diff2;
  logic [OFF_W-1:0] dict_off;
  logic [1:0]       dict_cnt;
  logic [AW-1:0]    off_red;
  logic [VW-1:0]    load_addr;

  // fold a raw offset into the ram range
  function automatic logic [AW-1:0] wrap_off(input logic [OFF_W-1:0] v);
    logic [VW-1:0] t;
    t = VW'(v);
    for (int k = 0; k < RED_STEPS; k++) begin
      if (t >= DEPTH_V) begin
        t = t - DEPTH_V;
      end
    end
    return t[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] p);
    return (p == LAST_A) ? '0 : p + AW'(1);
  endfunction

  // dictionary section decode
  always_comb begin
    diff3 = in_code_i - cfg_i.three_char_start;
    diff2 = in_code_i - cfg_i.two_char_start;
    if (in_code_i >= cfg_i.three_char_start) begin
      dict_off = OFF_W'({diff3, 1'b0}) + OFF_W'(diff3) + OFF_W'(cfg_i.three_char_offset);
      dict_cnt = 2'd3;
    end else if (in_code_i >= cfg_i.two_char_start) begin
      dict_off = OFF_W'({diff2, 1'b0}) + OFF_W'(cfg_i.two_char_start);
      dict_cnt = 2'd2;
    end else begin
      dict_off = OFF_W'(in_code_i);
      dict_cnt = 2'd1;
    end
  end

  assign off_red   = wrap_off(off_q);
  assign load_addr = VW'(in_dict_address_i);
  assign wr_addr_o = load_addr[AW-1:0];
  assign wr_data_o = in_dict_value_i;

  always_comb begin
    seq_d       = seq_q;
    phase_d     = phase_q;
    lit_d       = lit_q;
    space_d     = space_q;
    active_d    = active_q;
    cnt_d       = cnt_q;
    off_d       = off_q;
    ptr_d       = ptr_q;
    in_ready_o  = 1'b0;
    emit_o      = 1'b0;
    emit_item_o = '0;
    ram_cmd_o   = '0;
    rd_addr_o   = ptr_q;

    // a new string starts with fresh capacity
    cur_phase = active_q ? phase_q : PH_IDLE;
    cur_lit   = active_q ? lit_q : 8'd0;
    if (active_q) begin
      cur_space = space_q;
    end else begin
      cur_space = (in_capacity_i == 8'd0) ? 8'd1 : in_capacity_i;
    end

    case (seq_q)
      SQ_ACCEPT: begin
        in_ready_o = out_free_i;
        if (in_valid_i && out_free_i) begin
          if (in_op_i == OP_LOAD) begin
            ram_cmd_o.wr_en = (load_addr < DEPTH_V);
          end else begin
            active_d = 1'b1;
            space_d  = cur_space;
            phase_d  = cur_phase;
            lit_d    = cur_lit;
            case (cur_phase)
              PH_SKIP: begin
                if (in_code_i == TOK_END) begin
                  phase_d  = PH_IDLE;
                  active_d = 1'b0;
                end
              end
              PH_COUNT: begin
                lit_d   = in_code_i;
                phase_d = (in_code_i == 8'd0) ? PH_IDLE : PH_LIT;
              end
              PH_LIT, PH_CHAR: begin
                emit_o = 1'b1;
                if (cur_space <= 8'd1) begin
                  emit_item_o.last      = 1'b1;
                  emit_item_o.truncated = 1'b1;
                  phase_d = PH_SKIP;
                  lit_d   = 8'd0;
                end else begin
                  emit_item_o.out_char = in_code_i;
                  space_d = cur_space - 8'd1;
                  if (cur_phase == PH_CHAR) begin
                    phase_d = PH_IDLE;
                  end else begin
                    lit_d = cur_lit - 8'd1;
                    if (cur_lit == 8'd1) begin
                      phase_d = PH_IDLE;
                    end
                  end
                end
              end
              default: begin
                phase_d = PH_IDLE;
                if (in_code_i == TOK_END) begin
                  emit_o           = 1'b1;
                  emit_item_o.last = 1'b1;
                  active_d         = 1'b0;
                end else if (in_code_i == TOK_RUN) begin
                  phase_d = PH_COUNT;
                end else if (in_code_i == TOK_SINGLE) begin
                  phase_d = PH_CHAR;
                end else begin
                  off_d = dict_off;
                  cnt_d = dict_cnt;
                  seq_d = SQ_ADDR;
                end
              end
            endcase
          end
        end
      end
      SQ_ADDR: begin
        ram_cmd_o.rd_en = 1'b1;
        rd_addr_o       = off_red;
        ptr_d           = next_addr(off_red);
        seq_d           = SQ_DATA;
      end
      SQ_DATA: begin
        if (out_free_i) begin
          emit_o = 1'b1;
          if (space_q <= 8'd1) begin
            emit_item_o.last      = 1'b1;
            emit_item_o.truncated = 1'b1;
            phase_d = PH_SKIP;
            lit_d   = 8'd0;
            seq_d   = SQ_ACCEPT;
          end else begin
            emit_item_o.out_char = rd_data_i;
            space_d = space_q - 8'd1;
            if (cnt_q == 2'd1) begin
              seq_d = SQ_ACCEPT;
            end else begin
              cnt_d           = cnt_q - 2'd1;
              ram_cmd_o.rd_en = 1'b1;
              rd_addr_o       = ptr_q;
              ptr_d           = next_addr(ptr_q);
            end
          end
        end
      end
      default: begin
        seq_d = SQ_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= SQ_ACCEPT;
      phase_q  <= PH_IDLE;
      lit_q    <= 8'd0;
      space_q  <= 8'd0;
      active_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      seq_q    <= seq_d;
      phase_q  <= phase_d;
      lit_q    <= lit_d;
      space_q  <= space_d;
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    ptr_q <= ptr_d;
  end

endmodule

// ----- verif/dictionary_token_decompressor_test.sv -----
// dictionary_token_decompressor_test: self-checking stream test of the token decompressor,
// with a behavioral decoder that predicts every character word from the words it accepts.
// Depends on dtd_pkg and dictionary_token_decompressor.

module dictionary_token_decompressor_test;
  import dtd_pkg::*;

  localparam int DictDepth  = 1024;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic       op;
    logic [9:0] addr;
    logic [7:0] val;
    logic [7:0] code;
    logic [7:0] cap;
  } in_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_TWO_START;
  logic [9:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [9:0] dict_address, [17:10] dict_value, [25:18] code_byte, [33:26] capacity
  logic [39:0] s_axis_tdata = '0;
  // [0] operation
  logic        s_axis_tuser = OP_LOAD;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] out_char
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  // [0] truncated
  logic        m_axis_tuser;

  dictionary_token_decompressor #(
    .DICT_DEPTH(DictDepth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // decoder shadow state
  logic [7:0] dict_mem [DictDepth];
  phase_e     ph = PH_IDLE;
  logic [7:0] lit_left = '0;
  logic [7:0] room = '0;
  logic       str_on = 1'b0;
  logic [7:0] two_start = TWO_START_RST;
  logic [7:0] three_start = THREE_START_RST;
  logic [9:0] three_off = THREE_OFFSET_RST;

  // parse state as words are queued, and entries already loaded
  bit         dict_known [DictDepth];
  phase_e     gen_ph = PH_IDLE;
  logic [7:0] gen_lit = '0;
  logic [7:0] gen_room = '0;
  logic       gen_on = 1'b0;

  out_item_t  due_chars[$];
  in_word_t   stream_words[$];

  int  send_gap_pct = 26;
  int  recv_gap_pct = 46;
  logic rx_hold = 1'b0;
  logic hold_armed = 1'b0;
  int  mismatch_cnt = 0;
  int  cycle_cnt = 0;
  int  queued_words = 0;
  logic [7:0] str_cap = '0;
  logic       str_fresh = 1'b0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_cnt < 40) begin
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got, want);
    end
    mismatch_cnt++;
  endtask

  function automatic bit put_char(input logic [7:0] ch);
    if (room <= 8'd1) begin
      due_chars.push_back({8'd0, 1'b1, 1'b1});
      ph = PH_SKIP;
      lit_left = '0;
      return 1'b0;
    end
    due_chars.push_back({ch, 1'b0, 1'b0});
    room = room - 8'd1;
    return 1'b1;
  endfunction

  function automatic void decode_word(input logic op, input logic [39:0] d);
    logic [9:0] addr;
    logic [7:0] val;
    logic [7:0] code;
    logic [7:0] cap;
    int base;
    int cnt;
    addr = d[9:0];
    val  = d[17:10];
    code = d[25:18];
    cap  = d[33:26];
    if (op == OP_LOAD) begin
      dict_mem[addr] = val;
      return;
    end
    if (!str_on) begin
      str_on = 1'b1;
      room = (cap == 8'd0) ? 8'd1 : cap;
      ph = PH_IDLE;
      lit_left = '0;
    end
    case (ph)
      PH_SKIP: begin
        if (code == TOK_END) begin
          ph = PH_IDLE;
          str_on = 1'b0;
        end
      end
      PH_COUNT: begin
        lit_left = code;
        ph = (code == 8'd0) ? PH_IDLE : PH_LIT;
      end
      PH_LIT: begin
        if (put_char(code)) begin
          lit_left = lit_left - 8'd1;
          if (lit_left == 8'd0) ph = PH_IDLE;
        end
      end
      PH_CHAR: begin
        if (put_char(code)) ph = PH_IDLE;
      end
      default: begin
        ph = PH_IDLE;
        if (code == TOK_END) begin
          due_chars.push_back({8'd0, 1'b1, 1'b0});
          str_on = 1'b0;
        end else if (code == TOK_RUN) begin
          ph = PH_COUNT;
        end else if (code == TOK_SINGLE) begin
          ph = PH_CHAR;
        end else begin
          if (code >= three_start) begin
            base = (int'(code) - int'(three_start)) * 3 + int'(three_off);
            cnt = 3;
          end else if (code >= two_start) begin
            base = (int'(code) - int'(two_start)) * 2 + int'(two_start);
            cnt = 2;
          end else begin
            base = int'(code);
            cnt = 1;
          end
          for (int i = 0; i < cnt; i++) begin
            if (!put_char(dict_mem[(base + i) % DictDepth])) break;
          end
        end
      end
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin : driver
    in_word_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_word(s_axis_tuser, s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stream_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          w = stream_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= w.op;
          s_axis_tdata <= {6'd0, w.cap, w.code, w.val, w.addr};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    out_item_t due;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_chars.size() == 0) begin
          report_mismatch("unexpected word", m_axis_tdata, 0);
        end else begin
          due = due_chars.pop_front();
          if (m_axis_tdata !== due.out_char) report_mismatch("out_char", m_axis_tdata, due.out_char);
          if (m_axis_tlast !== due.last) report_mismatch("last", m_axis_tlast, due.last);
          if (m_axis_tuser !== due.truncated) begin
            report_mismatch("truncated", m_axis_tuser, due.truncated);
          end
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // long output stall while the sender keeps offering words
  initial begin
    wait (hold_armed);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("dictionary_token_decompressor test failed");
      $finish;
    end
  end

  task automatic push_load(input logic [9:0] addr, input logic [7:0] val);
    stream_words.push_back({OP_LOAD, addr, val, 8'($urandom_range(255)),
                            8'($urandom_range(255))});
    dict_known[addr] = 1'b1;
    queued_words++;
  endtask

  // follow the parse of queued words and load every entry a lookup will read
  task automatic plan_code(input logic [7:0] code, input logic [7:0] cap);
    int base;
    int cnt;
    int a;
    if (!gen_on) begin
      gen_on = 1'b1;
      gen_room = (cap == 8'd0) ? 8'd1 : cap;
      gen_ph = PH_IDLE;
      gen_lit = '0;
    end
    case (gen_ph)
      PH_SKIP: begin
        if (code == TOK_END) begin
          gen_ph = PH_IDLE;
          gen_on = 1'b0;
        end
      end
      PH_COUNT: begin
        gen_lit = code;
        gen_ph = (code == 8'd0) ? PH_IDLE : PH_LIT;
      end
      PH_LIT: begin
        if (gen_room <= 8'd1) begin
          gen_ph = PH_SKIP;
          gen_lit = '0;
        end else begin
          gen_room = gen_room - 8'd1;
          gen_lit = gen_lit - 8'd1;
          if (gen_lit == 8'd0) gen_ph = PH_IDLE;
        end
      end
      PH_CHAR: begin
        if (gen_room <= 8'd1) begin
          gen_ph = PH_SKIP;
          gen_lit = '0;
        end else begin
          gen_room = gen_room - 8'd1;
          gen_ph = PH_IDLE;
        end
      end
      default: begin
        gen_ph = PH_IDLE;
        if (code == TOK_END) begin
          gen_on = 1'b0;
        end else if (code == TOK_RUN) begin
          gen_ph = PH_COUNT;
        end else if (code == TOK_SINGLE) begin
          gen_ph = PH_CHAR;
        end else begin
          if (code >= three_start) begin
            base = (int'(code) - int'(three_start)) * 3 + int'(three_off);
            cnt = 3;
          end else if (code >= two_start) begin
            base = (int'(code) - int'(two_start)) * 2 + int'(two_start);
            cnt = 2;
          end else begin
            base = int'(code);
            cnt = 1;
          end
          for (int i = 0; i < cnt; i++) begin
            a = (base + i) % DictDepth;
            if (!dict_known[a]) push_load(10'(a), 8'($urandom_range(255)));
            if (gen_room <= 8'd1) begin
              gen_ph = PH_SKIP;
              gen_lit = '0;
              break;
            end
            gen_room = gen_room - 8'd1;
          end
        end
      end
    endcase
  endtask

  task automatic push_code(input logic [7:0] code, input logic [7:0] cap);
    plan_code(code, cap);
    stream_words.push_back({OP_DECODE, 10'($urandom_range(1023)), 8'($urandom_range(255)),
                            code, cap});
    queued_words++;
  endtask

  task automatic begin_str(input logic [7:0] cap);
    str_cap = cap;
    str_fresh = 1'b1;
  endtask

  // capacity only matters on the first word of a string
  task automatic push_str(input logic [7:0] code);
    push_code(code, str_fresh ? str_cap : 8'($urandom_range(255)));
    str_fresh = 1'b0;
  endtask

  task automatic gen_string();
    int n_tok;
    int cnt;
    int sent;
    case ($urandom_range(9))
      0:       begin_str(8'($urandom_range(1)));
      1, 2, 3: begin_str(8'($urandom_range(2, 8)));
      4:       begin_str(8'($urandom_range(41, 255)));
      default: begin_str(8'($urandom_range(9, 40)));
    endcase
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(9))
        0, 1: begin
          cnt = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 5);
          if ($urandom_range(11) == 0) cnt = $urandom_range(6, 255);
          push_str(TOK_RUN);
          push_str(8'(cnt));
          // long counts are cut short: a broken run
          sent = (cnt > 8) ? $urandom_range(0, 8) : cnt;
          for (int i = 0; i < sent; i++) push_str(8'($urandom_range(255)));
        end
        2: begin
          push_str(TOK_SINGLE);
          push_str(8'($urandom_range(255)));
        end
        default: push_str(8'($urandom_range(3, 255)));
      endcase
    end
    push_str(TOK_END);
  endtask

  task automatic gen_segment(input int n_words);
    int stop_at;
    stop_at = queued_words + n_words;
    while (queued_words < stop_at) begin
      case ($urandom_range(19))
        0, 1: begin
          repeat ($urandom_range(1, 3)) push_code(8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        2, 3, 4: push_load(10'($urandom_range(1023)), 8'($urandom_range(255)));
        default: gen_string();
      endcase
    end
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (stream_words.size() != 0 || s_axis_tvalid || due_chars.size() != 0);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_TWO_START:   two_start = val[7:0];
      CFG_THREE_START: three_start = val[7:0];
      default:         three_off = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_sections(input logic [7:0] two, input logic [7:0] three,
                              input logic [9:0] off);
    write_reg(CFG_TWO_START, {2'b00, two});
    write_reg(CFG_THREE_START, {2'b00, three});
    write_reg(CFG_THREE_OFFSET, off);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // entries are loaded just ahead of the first lookup that reads them
    // zero capacity: a bare terminator fits, a character does not
    begin_str(8'd0);
    push_str(TOK_END);
    begin_str(8'd0);
    push_str(TOK_SINGLE);
    push_str(8'h41);
    push_str(TOK_END);
    // every section boundary, single literal, empty and full runs
    begin_str(8'd255);
    push_str(8'd3);
    push_str(8'd127);
    push_str(8'd128);
    push_str(8'd191);
    push_str(8'd192);
    push_str(8'd255);
    push_str(TOK_SINGLE);
    push_str(8'hff);
    push_str(TOK_RUN);
    push_str(8'd0);
    push_str(TOK_RUN);
    push_str(8'd3);
    push_str(8'h00);
    push_str(8'h80);
    push_str(8'h7f);
    push_str(TOK_END);
    // overflow inside a three-char entry, then skip to the end token
    begin_str(8'd3);
    push_str(8'd255);
    push_str(TOK_SINGLE);
    push_str(TOK_END);
    // longest run count overflowing
    begin_str(8'd3);
    push_str(TOK_RUN);
    push_str(8'd255);
    push_str(8'h55);
    push_str(8'haa);
    push_str(8'h11);
    push_str(TOK_END);
    settle();

    gen_segment(25);
    settle();

    // offset at the top of the ram wraps around
    set_sections(8'd3, 8'd255, 10'd1023);
    hold_armed = 1'b1;
    gen_segment(15);
    settle();
    gen_segment(15);
    settle();

    send_gap_pct = 46;
    recv_gap_pct = 26;
    // three-char section below the two-char section
    set_sections(8'd255, 8'd3, 10'd0);
    gen_segment(25);
    settle();
    set_sections(8'($urandom_range(3, 255)), 8'($urandom_range(3, 255)),
                 10'($urandom_range(1023)));
    gen_segment(25);
    settle();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_sections(8'd255, 8'd255, 10'($urandom_range(1023)));
    gen_segment(25);
    settle();
    set_sections(TWO_START_RST, THREE_START_RST, THREE_OFFSET_RST);
    gen_segment(30);
    settle();

    if (mismatch_cnt == 0) begin
      $display("dictionary_token_decompressor test passed");
    end else begin
      $display("dictionary_token_decompressor test failed");
    end
    $finish;
  end

endmodule
